// ===== src/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the timing wheel scheduler.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int ID_W       = 16;
   localparam int DELAY_W    = 32;
   localparam int TICK_W     = 16;
   localparam int WHEEL_W    = 9;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // serial divider operand widths
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 16;

   localparam logic [TICK_W-1:0]  TICK_RESET  = 16'd1;
   localparam logic [WHEEL_W-1:0] WHEEL_RESET = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_LENGTH = 1'b0,
      CSR_WHEEL_TICKS = 1'b1
   } csr_reg_type;

   typedef enum logic [0:0] {
      REQ_ADD  = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_BAD_DELAY = 3'd1,
      KIND_SLOT_FULL = 3'd2,
      KIND_EXPIRED   = 3'd3,
      KIND_NONE      = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_DELAY,
      ST_DIV_SLOT,
      ST_CNT_WAIT,
      ST_DRAIN_RD,
      ST_DRAIN_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== src/tws_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface tws_req_if;
   import tws_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [ID_W-1:0]    timer_id;
   logic [DELAY_W-1:0] delay_units;

   modport source (output valid, output req_type, output timer_id, output delay_units,
                   input ready);
   modport sink   (input valid, input req_type, input timer_id, input delay_units,
                   output ready);
endinterface

interface tws_rsp_if;
   import tws_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [ID_W-1:0]   expired_id;
   logic              last;

   modport source (output valid, output result_kind, output expired_id, output last,
                   input ready);
   modport sink   (input valid, input result_kind, input expired_id, input last,
                   output ready);
endinterface

interface tws_csr_if;
   import tws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/timing_wheel_scheduler.sv =====
`timescale 1ns / 1ps
// a zero-delay add is answered with no divider pass; any other add first divides the delay by
// tick_length: a rejected delay is answered after that pass, an add that passes the check after a
// second pass for the slot modulo; a tick makes one divider pass for the slot modulo, reads the
// slot count, then gives one result per expired id, or a none result when its slot is empty
// one item in flight at a time: the next item can be accepted in the cycle after the last
// result is loaded; after reset the slot count memory is cleared before the first item
// ----------------------------------------------------------------------------
// timing_wheel_scheduler
// Single-level hashed timing wheel: slot counts and slot entries in RAM,
// a serial divider for delay scaling and slot wrap.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler #(
   parameter int WHEEL_SLOTS = 256,
   parameter int SLOT_DEPTH  = 8,
   parameter int ID_BITS     = 16
) (
   input  logic clock,
   input  logic reset,
   tws_req_if.sink   req_chan,
   tws_rsp_if.source rsp_chan,
   tws_csr_if.sink   csr_chan
);
   import tws_pkg::*;

   localparam int POS_W     = $clog2(WHEEL_SLOTS);
   localparam int WT_W      = $clog2(WHEEL_SLOTS + 1);
   localparam int CNT_W     = $clog2(SLOT_DEPTH + 1);
   localparam int ENT_DEPTH = WHEEL_SLOTS * SLOT_DEPTH;
   localparam int EA_W      = $clog2(ENT_DEPTH);

   // configuration
   logic [TICK_W-1:0]  tick_len_ff;
   logic [WHEEL_W-1:0] wheel_ticks_ff;
   logic [TICK_W-1:0]  tick_eff;
   logic [31:0]        wt_full;
   logic [WT_W-1:0]    wt_eff;

   // control and item state
   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   slot_ff, slot_in;
   logic [POS_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               is_tick_ff, is_tick_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [CNT_W-1:0]   num_ff, num_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   kind_type           res_kind_ff, res_kind_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;

   // output register
   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic               rsp_last_ff;
   logic               load_out;
   kind_type           out_kind;
   logic [ID_W-1:0]    out_id;
   logic               out_last;
   logic               out_free;

   // divider
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // memories
   logic               cnt_wr_en, cnt_rd_en;
   logic [POS_W-1:0]   cnt_wr_addr, cnt_rd_addr;
   logic [CNT_W-1:0]   cnt_wr_data, cnt_rd_data;
   logic               ent_wr_en, ent_rd_en;
   logic [EA_W-1:0]    ent_wr_addr, ent_rd_addr;
   logic [ID_BITS-1:0] ent_rd_data;

   logic               req_fire;
   logic [31:0]        req_id_wide;
   logic [31:0]        ent_id_wide;
   logic [31:0]        wt_wide;

   // effective configuration
   always_comb begin
      tick_eff = (tick_len_ff == '0) ? TICK_W'(1) : tick_len_ff;
      if (wheel_ticks_ff == '0) begin
         wt_full = 32'd1;
      end else if (32'(wheel_ticks_ff) > 32'(WHEEL_SLOTS)) begin
         wt_full = 32'(WHEEL_SLOTS);
      end else begin
         wt_full = 32'(wheel_ticks_ff);
      end
      wt_eff  = wt_full[WT_W-1:0];
      wt_wide = 32'(wt_eff);
   end

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff    <= TICK_RESET;
         wheel_ticks_ff <= WHEEL_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_reg_type'(csr_chan.index))
            CSR_TICK_LENGTH: begin
               tick_len_ff <= csr_chan.data[TICK_W-1:0];
            end
            CSR_WHEEL_TICKS: begin
               wheel_ticks_ff <= csr_chan.data[WHEEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_id_wide    = 32'(req_chan.timer_id);
   assign ent_id_wide    = 32'(ent_rd_data);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      slot_in     = slot_ff;
      clr_idx_in  = clr_idx_ff;
      is_tick_in  = is_tick_ff;
      id_in       = id_ff;
      num_in      = num_ff;
      idx_in      = idx_ff;
      res_kind_in = res_kind_ff;
      res_id_in   = res_id_ff;

      load_out = 1'b0;
      out_kind = res_kind_ff;
      out_id   = res_id_ff;
      out_last = 1'b1;

      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = DIVISOR_W'(wt_eff);

      cnt_wr_en   = 1'b0;
      cnt_wr_addr = slot_ff;
      cnt_wr_data = '0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = div_rsp.remainder[POS_W-1:0];
      ent_wr_en   = 1'b0;
      ent_wr_addr = EA_W'(slot_ff) * EA_W'(SLOT_DEPTH) + EA_W'(cnt_rd_data);
      ent_rd_en   = 1'b0;
      ent_rd_addr = EA_W'(slot_ff) * EA_W'(SLOT_DEPTH) + EA_W'(idx_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_idx_ff;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == POS_W'(WHEEL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               is_tick_in = (req_kind_type'(req_chan.req_type) == REQ_TICK);
               id_in      = req_id_wide[ID_BITS-1:0];
               if (req_kind_type'(req_chan.req_type) == REQ_TICK) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 32'(pos_ff) + 32'd1;
                  state_in         = ST_DIV_SLOT;
               end else if (req_chan.delay_units == '0) begin
                  // zero delay expires at once, nothing stored
                  res_kind_in = KIND_EXPIRED;
                  res_id_in   = ID_W'(req_id_wide[ID_BITS-1:0]);
                  state_in    = ST_RESP;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = req_chan.delay_units;
                  div_req.divisor  = DIVISOR_W'(tick_eff);
                  state_in         = ST_DIV_DELAY;
               end
            end
         end
         ST_DIV_DELAY: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0 || div_rsp.quotient > wt_wide) begin
                  res_kind_in = KIND_BAD_DELAY;
                  res_id_in   = '0;
                  state_in    = ST_RESP;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 32'(pos_ff) + div_rsp.quotient;
                  state_in         = ST_DIV_SLOT;
               end
            end
         end
         ST_DIV_SLOT: begin
            if (div_rsp.done) begin
               slot_in   = div_rsp.remainder[POS_W-1:0];
               cnt_rd_en = 1'b1;
               if (is_tick_ff) begin
                  pos_in = div_rsp.remainder[POS_W-1:0];
               end
               state_in = ST_CNT_WAIT;
            end
         end
         ST_CNT_WAIT: begin
            res_id_in = '0;
            if (!is_tick_ff) begin
               if (cnt_rd_data >= CNT_W'(SLOT_DEPTH)) begin
                  res_kind_in = KIND_SLOT_FULL;
               end else begin
                  ent_wr_en   = 1'b1;
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = cnt_rd_data + 1'b1;
                  res_kind_in = KIND_ACCEPTED;
               end
               state_in = ST_RESP;
            end else if (cnt_rd_data == '0) begin
               res_kind_in = KIND_NONE;
               state_in    = ST_RESP;
            end else begin
               num_in   = cnt_rd_data;
               idx_in   = '0;
               state_in = ST_DRAIN_RD;
            end
         end
         ST_DRAIN_RD: begin
            ent_rd_en = 1'b1;
            state_in  = ST_DRAIN_WR;
         end
         ST_DRAIN_WR: begin
            out_kind = KIND_EXPIRED;
            out_id   = ID_W'(ent_id_wide[ID_BITS-1:0]);
            out_last = (idx_ff + 1'b1 == num_ff);
            if (out_free) begin
               load_out = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == num_ff) begin
                  // slot drained, empty it
                  cnt_wr_en = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_DRAIN_RD;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pos_ff     <= '0;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         clr_idx_ff <= clr_idx_in;
      end
      slot_ff     <= slot_in;
      is_tick_ff  <= is_tick_in;
      id_ff       <= id_in;
      num_ff      <= num_in;
      idx_ff      <= idx_in;
      res_kind_ff <= res_kind_in;
      res_id_ff   <= res_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_kind_ff <= out_kind;
         rsp_id_ff   <= out_id;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.expired_id  = rsp_id_ff;
   assign rsp_chan.last        = rsp_last_ff;

   tws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tws_ram #(
      .WIDTH (CNT_W),
      .DEPTH (WHEEL_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   tws_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (ENT_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (id_ff),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

endmodule

// ===== src/tws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tws_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module tws_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tws_pkg::div_req_type div_req,
   output tws_pkg::div_rsp_type div_rsp
);
   import tws_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvsr_ff, dvsr_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[DIVISOR_W+1]) begin
            rem_in  = trial[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp = {done_ff, quot_ff, rem_ff};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timing wheel scheduler. A short list of
// directed requests covers the corner cases. Random adds and ticks then run under
// several tick lengths and wheel sizes. Every result is checked in order, against the
// result a directed row gives where it gives one, else against a behavioral copy of the wheel.
// ----------------------------------------------------------------------------
module tb_top;
   import tws_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int WHEEL_SLOTS     = 256;
   localparam int SLOT_DEPTH      = 8;
   localparam int SETTLE_CYCLES   = 100;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASES          = 7;
   localparam int PHASE_ITEMS     = 64;
   localparam int DIRECTED_ROWS   = 21;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] id;
      logic            last;
   } wheel_result_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [ID_W-1:0]    id;
      logic [DELAY_W-1:0] dly;
      logic               typed;
      kind_type           want_kind;
      logic [ID_W-1:0]    want_id;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   tws_req_if req_chan ();
   tws_rsp_if rsp_chan ();
   tws_csr_if csr_chan ();

   timing_wheel_scheduler #(
      .WHEEL_SLOTS (WHEEL_SLOTS),
      .SLOT_DEPTH  (SLOT_DEPTH),
      .ID_BITS     (ID_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // behavioral copy of the wheel
   logic [TICK_W-1:0]  cfg_tick_length = TICK_RESET;
   logic [WHEEL_W-1:0] cfg_wheel_ticks = WHEEL_RESET;
   int unsigned        wheel_pos = 0;
   int unsigned        slot_fill [WHEEL_SLOTS];
   logic [ID_W-1:0]    slot_ids [WHEEL_SLOTS][SLOT_DEPTH];

   wheel_result_type step_results [$];
   wheel_result_type wheel_results [$];
   wheel_result_type head_result;

   int error_count    = 0;
   int send_idle_pct  = 36;
   int recv_idle_pct  = 59;
   int quiet_cycles   = 0;
   bit hold_rsp       = 1'b0;

   // position starts at 0, tick length 1, wheel 256
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{REQ_ADD,  16'hFFFF, 32'd0,          1'b1, KIND_EXPIRED,   16'hFFFF},
      '{REQ_ADD,  16'h0000, 32'd0,          1'b1, KIND_EXPIRED,   16'h0000},
      '{REQ_ADD,  16'h0001, 32'd257,        1'b1, KIND_BAD_DELAY, 16'h0000},
      '{REQ_ADD,  16'h7777, 32'hFFFF_FFFF,  1'b1, KIND_BAD_DELAY, 16'h0000},
      '{REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF,  1'b1, KIND_NONE,      16'h0000},
      '{REQ_ADD,  16'h1234, 32'd1,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'hABCD, 32'd1,          1'b1, KIND_ACCEPTED,  16'h0000},
      // a full turn lands in the current slot
      '{REQ_ADD,  16'h5555, 32'd256,        1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_TICK, 16'h0000, 32'd0,          1'b0, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0100, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0101, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0102, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0103, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0104, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0105, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0106, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0107, 32'd3,          1'b1, KIND_ACCEPTED,  16'h0000},
      '{REQ_ADD,  16'h0108, 32'd3,          1'b1, KIND_SLOT_FULL, 16'h0000},
      '{REQ_TICK, 16'h0000, 32'd0,          1'b0, KIND_ACCEPTED,  16'h0000},
      '{REQ_TICK, 16'h0000, 32'd0,          1'b0, KIND_ACCEPTED,  16'h0000},
      // drains the full slot: eight ids in one go
      '{REQ_TICK, 16'h0000, 32'd0,          1'b0, KIND_ACCEPTED,  16'h0000}
   };

   // tick length and raw wheel size per phase; 16'hFFFF as wheel size saturates
   logic [CSR_DATA_W-1:0] phase_tick [PHASES] =
      '{16'd0, 16'd3, 16'hFFFF, 16'd7, 16'd1, 16'd100, 16'd2};
   logic [CSR_DATA_W-1:0] phase_wheel [PHASES] =
      '{16'd8, 16'd0, 16'hFFFF, 16'd1, 16'd16, 16'd3, 16'd256};

   function automatic wheel_result_type make_result(input kind_type kind,
                                                    input logic [ID_W-1:0] id,
                                                    input logic last);
      wheel_result_type r;
      r.kind = kind;
      r.id   = id;
      r.last = last;
      return r;
   endfunction

   // appends one expected result to the results of the current request
   function automatic void add_step(input wheel_result_type r);
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic int unsigned eff_tick_length();
      return (cfg_tick_length == 0) ? 1 : cfg_tick_length;
   endfunction

   function automatic int unsigned eff_wheel_size();
      if (cfg_wheel_ticks == 0) return 1;
      if (cfg_wheel_ticks > WHEEL_SLOTS) return WHEEL_SLOTS;
      return cfg_wheel_ticks;
   endfunction

   // updates the wheel copy and leaves the results of one request in step_results
   function automatic void apply_request(input req_kind_type kind,
                                         input logic [ID_W-1:0] id,
                                         input logic [DELAY_W-1:0] dly);
      longint unsigned tl;
      longint unsigned wt;
      longint unsigned span;
      int unsigned     slot;
      int unsigned     n;
      tl   = eff_tick_length();
      wt   = eff_wheel_size();
      span = dly;
      step_results.delete();
      if (kind == REQ_TICK) begin
         wheel_pos = 32'((wheel_pos + 1) % wt);
         n = slot_fill[wheel_pos];
         if (n == 0) add_step(make_result(KIND_NONE, '0, 1'b1));
         for (int i = 0; i < n; i++)
            add_step(make_result(KIND_EXPIRED, slot_ids[wheel_pos][i], i == n - 1));
         slot_fill[wheel_pos] = 0;
      end else if (span % tl != 0 || span / tl > wt) begin
         add_step(make_result(KIND_BAD_DELAY, '0, 1'b1));
      end else if (span == 0) begin
         add_step(make_result(KIND_EXPIRED, id, 1'b1));
      end else begin
         slot = 32'((wheel_pos + span / tl) % wt);
         if (slot_fill[slot] >= SLOT_DEPTH) begin
            add_step(make_result(KIND_SLOT_FULL, '0, 1'b1));
         end else begin
            slot_ids[slot][slot_fill[slot]] = id;
            slot_fill[slot]++;
            add_step(make_result(KIND_ACCEPTED, '0, 1'b1));
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic issue_request(input req_kind_type kind,
                                input logic [ID_W-1:0] id,
                                input logic [DELAY_W-1:0] dly,
                                input logic typed = 1'b0,
                                input kind_type want_kind = KIND_ACCEPTED,
                                input logic [ID_W-1:0] want_id = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.req_type    = kind;
      req_chan.timer_id    = id;
      req_chan.delay_units = dly;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      apply_request(kind, id, dly);
      if (typed) begin
         step_results.delete();
         add_step(make_result(want_kind, want_id, 1'b1));
      end
      foreach (step_results[i]) wheel_results.insert(wheel_results.size(), step_results[i]);
      @(negedge clock);
   endtask

   task automatic random_request();
      int unsigned        tl;
      int unsigned        wt;
      int unsigned        roll;
      req_kind_type       kind;
      logic [DELAY_W-1:0] dly;
      tl   = eff_tick_length();
      wt   = eff_wheel_size();
      roll = $urandom_range(99);
      kind = REQ_ADD;
      if (roll < 42) begin
         kind = REQ_TICK;
         dly  = $urandom;
      end else if (roll < 88) begin
         dly = $urandom_range(wt) * tl;
      end else if (roll < 94) begin
         dly = $urandom;
      end else if (roll < 97) begin
         dly = (wt + 1) * tl;
      end else begin
         dly = $urandom_range(wt) * tl + 1;
      end
      issue_request(kind, ID_W'($urandom), dly);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      if (idx == CSR_TICK_LENGTH) cfg_tick_length = value;
      else cfg_wheel_ticks = value[WHEEL_W-1:0];
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic wait_for_results();
      req_chan.valid = 1'b0;
      while (wheel_results.size() != 0) @(negedge clock);
   endtask

   // waits for every expected result, then lets the clock run on with no requests
   task automatic drain_wheel();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_ADD;
      req_chan.timer_id    = '0;
      req_chan.delay_units = '0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_TICK_LENGTH;
      csr_chan.data        = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         issue_request(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].dly,
                       directed_rows[r].typed, directed_rows[r].want_kind,
                       directed_rows[r].want_id);

      for (int p = 0; p < PHASES; p++) begin
         drain_wheel();
         if (p < 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 59;
         end else if (p < 5) begin
            send_idle_pct = 59;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_TICK_LENGTH, phase_tick[p]);
         write_csr(CSR_WHEEL_TICKS, phase_wheel[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long response back-pressure while requests keep coming
            if (p == 0 && n == 20) hold_rsp = 1'b1;
            if (p == 4 && n == 32) wait_for_results();
            random_request();
         end
      end

      drain_wheel();
      if (error_count == 0) begin
         $display("timing_wheel_scheduler regression: pass");
      end else begin
         $display("timing_wheel_scheduler regression: fail");
      end
      $finish;
   end

   initial begin
      bit hold_taken;
      hold_taken     = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_taken) begin
            hold_taken     = 1'b1;
            rsp_chan.ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (wheel_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d id %h last %b",
                                      rsp_chan.result_kind, rsp_chan.expired_id,
                                      rsp_chan.last));
         end else begin
            head_result = wheel_results.pop_front();
            if (rsp_chan.result_kind !== head_result.kind)
               report_mismatch($sformatf("result_kind %0d, expected %0d",
                                         rsp_chan.result_kind, head_result.kind));
            if (rsp_chan.expired_id !== head_result.id)
               report_mismatch($sformatf("expired_id %h, expected %h",
                                         rsp_chan.expired_id, head_result.id));
            if (rsp_chan.last !== head_result.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_chan.last, head_result.last));
         end
      end
   end

   // cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_chan.valid & req_chan.ready) === 1'b1 ||
          (rsp_chan.valid & rsp_chan.ready) === 1'b1 ||
          (csr_chan.valid & csr_chan.ready) === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout at %0t ns", $time);
         $display("timing_wheel_scheduler regression: fail");
         $finish;
      end
   end

endmodule
